### src/iida_pkg.sv
package iida_pkg;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

### src/iida_in_if.sv
interface iida_in_if
  import iida_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

### src/iida_out_if.sv
interface iida_out_if
  import iida_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_value;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink (input valid, input status, input read_value, input count, output ready);
endinterface

### src/iida_ctrl.sv
module iida_ctrl
  import iida_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign ctrl_o.capture = accept;
  assign ctrl_o.execute = (state_q == ST_EXEC);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/iida_dpath.sv
module iida_dpath
  import iida_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [COUNT_W-1:0]       count_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RDN  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  logic [CMD_W-1:0]         cmd_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] val_q;

  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic [CW-1:0]            count_q, count_d;

  logic [STATUS_W-1:0]      status_q, status_d;
  logic signed [DATA_W-1:0] rd_q, rd_d, rd_mux;
  logic [COUNT_W-1:0]       cnt_out_q;

  logic [CMPW-1:0] pos_ext, cnt_ext, cnt_d_ext;
  logic            ins_oob, acc_oob, full, do_ins, do_del;

  assign pos_ext   = CMPW'(pos_q);
  assign cnt_ext   = CMPW'(count_q);
  assign cnt_d_ext = CMPW'(count_d);
  assign ins_oob   = pos_ext > cnt_ext;
  assign acc_oob   = pos_ext >= cnt_ext;
  assign full      = count_q == CW'(DEPTH);

  always_comb begin
    rd_mux = '0;
    for (int j = 0; j < RDN; j++) begin
      if (pos_q == POS_W'(j)) begin
        rd_mux = entries_q[j];
      end
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    rd_d     = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        if (ins_oob) begin
          status_d = STATUS_OOB;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (acc_oob) begin
          status_d = STATUS_OOB;
        end else begin
          do_del = 1'b1;
        end
      end
      CMD_READ: begin
        if (acc_oob) begin
          status_d = STATUS_OOB;
        end else begin
          rd_d = rd_mux;
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_del) begin
      count_d = count_q - CW'(1);
    end
  end

  // one cell per entry, each moves toward or away from the position
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i > 0) ? i - 1 : 0;
    localparam int NEXT = (i < DEPTH - 1) ? i + 1 : i;
    logic above, at;
    assign above = CMPW'(i) > pos_ext;
    assign at    = CMPW'(i) == pos_ext;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.execute) begin
        if (do_ins) begin
          if (above) begin
            entries_q[i] <= entries_q[PREV];
          end else if (at) begin
            entries_q[i] <= val_q;
          end
        end else if (do_del && (above || at)) begin
          entries_q[i] <= entries_q[NEXT];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (ctrl_i.execute) begin
      status_q  <= status_d;
      rd_q      <= rd_d;
      cnt_out_q <= cnt_d_ext[COUNT_W-1:0];
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rd_q;
  assign count_o      = cnt_out_q;

endmodule

### src/indexed_insert_delete_array_core.sv
// channel | dir | handshake     | word
// in_i    | in  | valid / ready | cmd, position, value
// out_o   | out | valid / ready | status, read_value, count
//
// each command is captured in the idle state; then, in the exec state, every
// cell shifts in parallel and the result register loads
// a new word is taken once the previous result is taken, or in the same cycle
// as it is taken, and never while a command is in the exec state
// reset clears the element count and the handshake state; entries hold no reset
// a stalled output holds its word and blocks all input until that word is taken
module indexed_insert_delete_array_core
  import iida_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  iida_in_if.sink   in_i,
  iida_out_if.source out_o
);

  ctrl_t ctrl;

  iida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  iida_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cmd_i        (in_i.cmd),
    .position_i   (in_i.position),
    .value_i      (in_i.value),
    .status_o     (out_o.status),
    .read_value_o (out_o.read_value),
    .count_o      (out_o.count)
  );

`ifndef NO_ASSERTIONS
  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !out_o.valid)
    else $error("result valid in cycle after accept");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> ##1 out_o.valid)
    else $error("no result two cycles after accept");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STATUS_FULL |-> out_o.count == COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != STATUS_OK |-> out_o.read_value == '0)
    else $error("read value nonzero on failed command");
`endif

endmodule
